// ===== src/slne_pkg.sv =====
// Package for the sorted leaf node engine: sizes, operation and status codes,
// controller state type and the command/status structs. No dependencies.
`default_nettype none
package slne_pkg;
  localparam int Capacity = 16;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int KeyW = 32;
  localparam int ValW = 32;
  localparam int Keep = Capacity / 2;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_UPDATED  = 3'd1;
  localparam logic [2:0] ST_SPLIT    = 3'd2;
  localparam logic [2:0] ST_DELETED  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;
  localparam logic [2:0] ST_FOUND    = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_PROBE, S_DECIDE, S_SHIFT_R, S_SHIFT_L,
    S_SPLIT_RD, S_SPLIT_OUT, S_DONE
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;        // capture request, init search bounds
    logic probe;       // apply one binary search step
    logic rd_pos;      // read entry at lower bound for the hit test
    logic shift_r;     // move entry ptr-1 to ptr, ptr--
    logic shift_l;     // move entry ptr+1 to ptr, ptr++
    logic ptr_pos;     // ptr = pos (start of left shift)
    logic ptr_cnt;     // ptr = count (start of right shift)
    logic wr_new;      // write request at ptr
    logic wr_val;      // write value at pos
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_keep;
    logic split_init;  // merged index = Keep
    logic split_rd;    // fetch merged entry at split index
    logic split_adv;   // advance merged index
    logic emit;
    logic [2:0] st;
    logic use_val;     // result carries read value
    logic use_split;   // result carries merged entry
    logic emit_last;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [1:0] func;
    logic search_done;
    logic hit;
    logic full;
    logic shift_done_r;
    logic shift_done_l;
    logic split_end;
  } stat_t;
endpackage
`default_nettype wire

// ===== src/slne_ctrl.sv =====
// Controller state machine for the sorted leaf node engine.
// Depends on slne_pkg; drives slne_dp through cmd_t, reads stat_t.
`default_nettype none
module slne_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  slne_pkg::stat_t   stat,
  output slne_pkg::cmd_t    cmd,
  output logic              busy
);
  slne_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= slne_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = 1'b1;
    case (state)
      slne_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load = 1'b1;
          state_next = slne_pkg::S_SEARCH;
        end
      end
      slne_pkg::S_SEARCH: begin
        if (stat.search_done) begin
          cmd.rd_pos = 1'b1;
          state_next = slne_pkg::S_DECIDE;
        end else begin
          state_next = slne_pkg::S_PROBE;
        end
      end
      // The key read is registered, so each probe passes through S_SEARCH, then S_PROBE.
      slne_pkg::S_PROBE: begin
        cmd.probe = 1'b1;
        state_next = slne_pkg::S_SEARCH;
      end
      slne_pkg::S_DECIDE: begin
        state_next = slne_pkg::S_DONE;
        case (stat.func)
          slne_pkg::FUNC_INSERT: begin
            if (stat.hit) begin
              cmd.wr_val = 1'b1;
              cmd.emit = 1'b1; cmd.st = slne_pkg::ST_UPDATED; cmd.emit_last = 1'b1;
            end else if (stat.full) begin
              cmd.split_init = 1'b1;
              state_next = slne_pkg::S_SPLIT_RD;
            end else begin
              cmd.ptr_cnt = 1'b1;
              state_next = slne_pkg::S_SHIFT_R;
            end
          end
          slne_pkg::FUNC_DELETE: begin
            if (stat.hit) begin
              cmd.ptr_pos = 1'b1;
              state_next = slne_pkg::S_SHIFT_L;
            end else begin
              cmd.emit = 1'b1; cmd.st = slne_pkg::ST_NOTFOUND; cmd.emit_last = 1'b1;
            end
          end
          slne_pkg::FUNC_LOOKUP: begin
            cmd.emit = 1'b1; cmd.emit_last = 1'b1;
            cmd.st = stat.hit ? slne_pkg::ST_FOUND : slne_pkg::ST_NOTFOUND;
            cmd.use_val = stat.hit;
          end
          default: begin
            cmd.emit = 1'b1; cmd.st = slne_pkg::ST_NOTFOUND; cmd.emit_last = 1'b1;
          end
        endcase
      end
      slne_pkg::S_SHIFT_R: begin
        if (stat.shift_done_r) begin
          cmd.wr_new = 1'b1; cmd.cnt_inc = 1'b1;
          cmd.emit = 1'b1; cmd.st = slne_pkg::ST_INSERTED; cmd.emit_last = 1'b1;
          state_next = slne_pkg::S_DONE;
        end else begin
          cmd.shift_r = 1'b1;
        end
      end
      slne_pkg::S_SHIFT_L: begin
        if (stat.shift_done_l) begin
          cmd.cnt_dec = 1'b1;
          cmd.emit = 1'b1; cmd.st = slne_pkg::ST_DELETED; cmd.emit_last = 1'b1;
          state_next = slne_pkg::S_DONE;
        end else begin
          cmd.shift_l = 1'b1;
        end
      end
      slne_pkg::S_SPLIT_RD: begin
        cmd.split_rd = 1'b1;
        state_next = slne_pkg::S_SPLIT_OUT;
      end
      // Each merged entry of the upper half is read, then emitted; the lower
      // half needs rewriting only where the new entry lands below Keep.
      slne_pkg::S_SPLIT_OUT: begin
        cmd.emit = 1'b1; cmd.st = slne_pkg::ST_SPLIT; cmd.use_split = 1'b1;
        cmd.emit_last = stat.split_end;
        cmd.split_adv = 1'b1;
        if (stat.split_end) begin
          cmd.cnt_keep = 1'b1;
          cmd.ptr_cnt = 1'b1;
          state_next = slne_pkg::S_DONE;
        end else begin
          state_next = slne_pkg::S_SPLIT_RD;
        end
      end
      slne_pkg::S_DONE: begin
        state_next = slne_pkg::S_IDLE;
      end
      default: state_next = slne_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/slne_dp.sv =====
// Datapath for the sorted leaf node engine: key/value store, search bounds,
// shift pointer, split sequencing and the result register. Depends on slne_pkg.
`default_nettype none
module slne_dp (
  input  wire                        clk,
  input  wire                        rst,
  input  wire [1:0]                  func,
  input  wire [slne_pkg::KeyW-1:0]   key,
  input  wire [slne_pkg::ValW-1:0]   value,
  input  slne_pkg::cmd_t             cmd,
  output slne_pkg::stat_t            stat,
  output logic                       done,
  output logic [2:0]                 status,
  output logic [slne_pkg::KeyW-1:0]  out_key,
  output logic [slne_pkg::ValW-1:0]  out_value,
  output logic                       last
);
  localparam int IW = slne_pkg::IdxW;
  localparam int CW = slne_pkg::CntW;

  logic [slne_pkg::KeyW-1:0] keys [slne_pkg::Capacity];
  logic [slne_pkg::ValW-1:0] vals [slne_pkg::Capacity];

  logic [1:0]                r_func;
  logic [slne_pkg::KeyW-1:0] r_key;
  logic [slne_pkg::ValW-1:0] r_val;
  logic [CW-1:0] count, lo, hi, ptr, midx;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic [slne_pkg::KeyW-1:0] rd_key;
  logic [slne_pkg::ValW-1:0] rd_val;
  logic [slne_pkg::KeyW-1:0] probe_key;

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid = mid_sum[CW:1];

  // Merged index m maps to store entry m-1 above pos, m below, new at pos.
  logic [CW-1:0] src_idx;
  logic          src_new;
  always_comb begin
    src_new = (midx == lo);
    src_idx = (midx > lo) ? midx - CW'(1) : midx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      if (cmd.cnt_inc) count <= count + CW'(1);
      else if (cmd.cnt_dec) count <= count - CW'(1);
      else if (cmd.cnt_keep) count <= CW'(slne_pkg::Keep);
    end
  end

  always_ff @(posedge clk) begin
    probe_key <= keys[mid[IW-1:0]];
    if (cmd.load) begin
      r_func <= func; r_key <= key; r_val <= value;
      lo <= '0; hi <= count;
    end
    if (cmd.probe) begin
      if (probe_key < r_key) lo <= mid + CW'(1);
      else hi <= mid;
    end
    if (cmd.rd_pos) begin
      rd_key <= keys[lo[IW-1:0]];
      rd_val <= vals[lo[IW-1:0]];
    end
    if (cmd.ptr_pos) ptr <= lo;
    if (cmd.ptr_cnt) ptr <= count;
    if (cmd.shift_r) begin
      keys[ptr[IW-1:0]] <= keys[ptr[IW-1:0] - IW'(1)];
      vals[ptr[IW-1:0]] <= vals[ptr[IW-1:0] - IW'(1)];
      ptr <= ptr - CW'(1);
    end
    if (cmd.shift_l) begin
      keys[ptr[IW-1:0]] <= keys[ptr[IW-1:0] + IW'(1)];
      vals[ptr[IW-1:0]] <= vals[ptr[IW-1:0] + IW'(1)];
      ptr <= ptr + CW'(1);
    end
    if (cmd.wr_new) begin
      keys[ptr[IW-1:0]] <= r_key;
      vals[ptr[IW-1:0]] <= r_val;
    end
    if (cmd.wr_val) vals[lo[IW-1:0]] <= r_val;
    if (cmd.split_init) midx <= CW'(slne_pkg::Keep);
    if (cmd.split_rd) begin
      rd_key <= src_new ? r_key : keys[src_idx[IW-1:0]];
      rd_val <= src_new ? r_val : vals[src_idx[IW-1:0]];
    end
    // The lower half is rewritten from the top down once the upper half
    // is out: shift Keep-1 down to pos, then place the new entry.
    if (cmd.split_adv) midx <= midx + CW'(1);
    if (cmd.cnt_keep && lo < CW'(slne_pkg::Keep)) begin
      for (int i = slne_pkg::Capacity - 1; i > 0; i--) begin
        if (i < slne_pkg::Keep && CW'(i) > lo) begin
          keys[IW'(i)] <= keys[IW'(i-1)];
          vals[IW'(i)] <= vals[IW'(i-1)];
        end
      end
      keys[lo[IW-1:0]] <= r_key;
      vals[lo[IW-1:0]] <= r_val;
    end
  end

  always_comb begin
    stat.func = r_func;
    stat.search_done = (lo == hi);
    stat.hit = (lo < count) && (rd_key == r_key);
    stat.full = (count >= CW'(slne_pkg::Capacity));
    stat.shift_done_r = (ptr == lo);
    stat.shift_done_l = (ptr + CW'(1) >= count);
    stat.split_end = (midx == CW'(slne_pkg::Capacity));
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= cmd.emit;
    if (cmd.emit) begin
      status    <= cmd.st;
      out_key   <= cmd.use_split ? rd_key : '0;
      out_value <= (cmd.use_split || cmd.use_val) ? rd_val : '0;
      last      <= cmd.emit_last;
    end
  end
endmodule
`default_nettype wire

// ===== src/sorted_leaf_node_engine.sv =====
// Top level of the sorted leaf node engine: controller plus datapath.
// Depends on slne_pkg, slne_ctrl and slne_dp.
//   channel   handshake           payload
//   request   start / busy        func, key, value
//   result    done (one cycle)    status, out_key, out_value, last
// After acceptance busy stays high through the binary search (up to five
// probes with 16 entries), the decision and the S_DONE state.
// Insert or delete then moves the shifted entries one at a time; a split reads
// and then emits each upper-half entry in turn, one store access per step.
// Reset is synchronous and empties the store; the receiver cannot stall.
`default_nettype none
module sorted_leaf_node_engine (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [1:0]  func,
  input  wire  [31:0] key,
  input  wire  [31:0] value,
  output logic        busy,
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] out_key,
  output logic [31:0] out_value,
  output logic        last
);
  slne_pkg::cmd_t  cmd;
  slne_pkg::stat_t stat;

  slne_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat), .cmd(cmd), .busy(busy)
  );

  slne_dp u_dp (
    .clk(clk), .rst(rst), .func(func), .key(key), .value(value),
    .cmd(cmd), .stat(stat), .done(done), .status(status),
    .out_key(out_key), .out_value(out_value), .last(last)
  );
endmodule
`default_nettype wire

// ===== src/slne_checker.sv =====
// Port-level assertions for the sorted leaf node engine, bound to the top level.
// Depends on the sorted_leaf_node_engine ports and slne_pkg status codes.
`default_nettype none
module slne_props (
  input wire        clk,
  input wire        rst,
  input wire        start,
  input wire        busy,
  input wire        done,
  input wire [2:0]  status,
  input wire        last
);
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("no busy after accepted start");
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= slne_pkg::ST_FOUND) else $error("status out of range");
  a_nonsplit_last: assert property (@(posedge clk) disable iff (rst)
    done && status != slne_pkg::ST_SPLIT |-> last)
    else $error("single result without last");
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    done && last |=> !done) else $error("result after last");
endmodule

bind sorted_leaf_node_engine slne_props u_slne_props (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .status(status), .last(last)
);
`default_nettype wire
